// ----- rtl/core/plam_pkg.sv -----
// ============================================================================
// plam_pkg
// Shared types, constants and register indexes of the power line alarm
// monitor.
// ============================================================================
package plam_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int TIME_BITS      = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic        [TIME_BITS-1:0]   t_time;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CURRENT_LIMIT      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VOLTAGE_LIMIT      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ALLOWED_OVER_TICKS = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PERIOD_LOW         = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PERIOD_HIGH        = 3'd4;

    localparam t_sample CURRENT_LIMIT_RST      = 16'sd32767;
    localparam t_sample VOLTAGE_LIMIT_RST      = 16'sd32767;
    localparam t_time   ALLOWED_OVER_TICKS_RST = 32'd1000000;
    localparam t_time   PERIOD_LOW_RST         = 32'd19802;
    localparam t_time   PERIOD_HIGH_RST        = 32'd20202;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] current_sample;
        logic signed [SAMPLE_BITS-1:0] voltage_sample;
        logic        [TIME_BITS-1:0]   sample_time;
    } t_in_item;

    typedef struct packed {
        logic                 current_over_alarm;
        logic                 voltage_over_alarm;
        logic                 current_period_valid;
        logic [TIME_BITS-1:0] current_period;
        logic                 current_freq_alarm;
        logic                 voltage_period_valid;
        logic [TIME_BITS-1:0] voltage_period;
        logic                 voltage_freq_alarm;
    } t_out_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] limit;
        logic        [TIME_BITS-1:0]   allowed_over_ticks;
        logic        [TIME_BITS-1:0]   period_low;
        logic        [TIME_BITS-1:0]   period_high;
    } t_chan_cfg;

    typedef struct packed {
        logic                 over_alarm;
        logic                 period_valid;
        logic [TIME_BITS-1:0] period;
        logic                 freq_alarm;
    } t_chan_res;

endpackage

// ----- rtl/core/power_line_alarm_monitor.sv -----
// ============================================================================
// power_line_alarm_monitor
// Over-limit timing and period monitoring of a current and a voltage
// sample stream.
// ============================================================================
//  channel   handshake               payload
//  in        i_valid / o_stall       i_item   (current, voltage, time)
//  out       o_valid / i_stall       o_result (alarms, periods)
//  config    i_cfg_wr_en             i_cfg_index, i_cfg_data
//
//  One request per cycle while o_stall is low.
//  The input register feeds one pass of channel logic into the result register.
//  Synchronous active-low reset clears all tracking state and loads defaults.
//  o_stall rises only while both registers are full and i_stall is high.
// ============================================================================
module power_line_alarm_monitor (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  plam_pkg::t_in_item                    i_item,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output plam_pkg::t_out_item                   o_result,
    input  logic                                  i_cfg_wr_en,
    input  logic [plam_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [plam_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import plam_pkg::*;

    t_sample   r_current_limit;
    t_sample   r_voltage_limit;
    t_time     r_allowed;
    t_time     r_period_low;
    t_time     r_period_high;

    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_time     r_prev_time;
    logic [1:0] r_seen;

    logic      out_ready;
    logic      advance;
    logic      accept;
    t_chan_cfg cur_cfg;
    t_chan_cfg volt_cfg;
    t_chan_res cur_res;
    t_chan_res volt_res;
    t_out_item n_out;

    assign out_ready = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !out_ready;
    assign accept    = i_valid && !o_stall;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_limit <= CURRENT_LIMIT_RST;
            r_voltage_limit <= VOLTAGE_LIMIT_RST;
            r_allowed       <= ALLOWED_OVER_TICKS_RST;
            r_period_low    <= PERIOD_LOW_RST;
            r_period_high   <= PERIOD_HIGH_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_CURRENT_LIMIT:      r_current_limit <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_VOLTAGE_LIMIT:      r_voltage_limit <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_ALLOWED_OVER_TICKS: r_allowed       <= i_cfg_data[TIME_BITS-1:0];
                CFG_PERIOD_LOW:         r_period_low    <= i_cfg_data[TIME_BITS-1:0];
                CFG_PERIOD_HIGH:        r_period_high   <= i_cfg_data[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cur_cfg.limit               = r_current_limit;
        cur_cfg.allowed_over_ticks  = r_allowed;
        cur_cfg.period_low          = r_period_low;
        cur_cfg.period_high         = r_period_high;
        volt_cfg.limit              = r_voltage_limit;
        volt_cfg.allowed_over_ticks = r_allowed;
        volt_cfg.period_low         = r_period_low;
        volt_cfg.period_high        = r_period_high;
    end

    plam_chan u_cur (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_sample    (r_in.current_sample),
        .i_time      (r_in.sample_time),
        .i_prev_time (r_prev_time),
        .i_have_two  (r_seen[1]),
        .i_cfg       (cur_cfg),
        .o_res       (cur_res)
    );

    plam_chan u_volt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_sample    (r_in.voltage_sample),
        .i_time      (r_in.sample_time),
        .i_prev_time (r_prev_time),
        .i_have_two  (r_seen[1]),
        .i_cfg       (volt_cfg),
        .o_res       (volt_res)
    );

    always_comb begin
        n_out.current_over_alarm   = cur_res.over_alarm;
        n_out.voltage_over_alarm   = volt_res.over_alarm;
        n_out.current_period_valid = cur_res.period_valid;
        n_out.current_period       = cur_res.period;
        n_out.current_freq_alarm   = cur_res.freq_alarm;
        n_out.voltage_period_valid = volt_res.period_valid;
        n_out.voltage_period       = volt_res.period;
        n_out.voltage_freq_alarm   = volt_res.freq_alarm;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev_time <= '0;
            r_seen      <= 2'd0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_prev_time <= r_in.sample_time;
                if (!r_seen[1]) begin
                    r_seen <= r_seen + 2'd1;
                end
            end
        end
    end

endmodule

// ----- rtl/core/plam_chan.sv -----
// ============================================================================
// plam_chan
// One measurement channel: over-limit time total with saturation, strict
// local peak detection and period check against the allowed band.
// ============================================================================
module plam_chan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  plam_pkg::t_sample   i_sample,
    input  plam_pkg::t_time     i_time,
    input  plam_pkg::t_time     i_prev_time,
    input  logic                i_have_two,
    input  plam_pkg::t_chan_cfg i_cfg,
    output plam_pkg::t_chan_res o_res
);
    import plam_pkg::*;

    t_sample              r_prev1;
    t_sample              r_prev2;
    t_time                r_last_peak;
    logic                 r_peak_seen;
    logic                 r_was_over;
    t_time                r_total;

    logic                 over;
    t_time                dt;
    logic [TIME_BITS:0]   sum;
    t_time                n_total;
    logic                 peak;
    t_time                period;
    logic                 new_period;

    always_comb begin
        over    = i_sample > i_cfg.limit;
        dt      = i_time - i_prev_time;
        sum     = {1'b0, r_total} + {1'b0, dt};
        if (over && r_was_over) begin
            n_total = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        end else begin
            n_total = '0;
        end
        peak       = i_have_two && (r_prev1 > r_prev2) && (r_prev1 > i_sample);
        period     = i_prev_time - r_last_peak;
        new_period = peak && r_peak_seen;

        o_res.over_alarm   = n_total > i_cfg.allowed_over_ticks;
        o_res.period_valid = new_period;
        o_res.period       = new_period ? period : '0;
        o_res.freq_alarm   = new_period &&
                             ((period < i_cfg.period_low) || (period > i_cfg.period_high));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev1     <= '0;
            r_prev2     <= '0;
            r_last_peak <= '0;
            r_peak_seen <= 1'b0;
            r_was_over  <= 1'b0;
            r_total     <= '0;
        end else if (i_advance) begin
            r_prev1    <= i_sample;
            r_prev2    <= r_prev1;
            r_was_over <= over;
            r_total    <= n_total;
            if (peak) begin
                r_last_peak <= i_prev_time;
                r_peak_seen <= 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/plam_checker.sv -----
// ============================================================================
// plam_checker
// Port-level checks of the power line alarm monitor, bound to the top level.
// ============================================================================
module plam_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input plam_pkg::t_out_item o_result
);
    import plam_pkg::*;

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("result changed while stalled");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with room downstream");

    a_cur_period_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.current_period_valid |->
            o_result.current_period == '0 && !o_result.current_freq_alarm)
        else $error("current period fields set without a new period");

    a_volt_period_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.voltage_period_valid |->
            o_result.voltage_period == '0 && !o_result.voltage_freq_alarm)
        else $error("voltage period fields set without a new period");

endmodule

bind power_line_alarm_monitor plam_checker u_plam_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_result (o_result)
);

// ----- bench/power_line_alarm_monitor_check.sv -----
`timescale 1ns / 100ps
// ============================================================================
// power_line_alarm_monitor_check
// Watches the request, result and register ports of the alarm monitor. It
// keeps its own copy of the settings and of the per-channel tracking state.
// For every accepted request it predicts the result, and it compares each
// accepted result field by field with the oldest prediction.
// ============================================================================
module power_line_alarm_monitor_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    input  logic                                i_req_stall,
    input  plam_pkg::t_in_item                  i_req,
    input  logic                                i_res_valid,
    input  logic                                i_res_stall,
    input  plam_pkg::t_out_item                 i_res,
    input  logic                                i_cfg_wr_en,
    input  logic [plam_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [plam_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked,
    output int                                  o_periods,
    output int                                  o_freq_alarms,
    output int                                  o_over_alarms
);
    import plam_pkg::*;

    localparam int CH_CURRENT   = 0;
    localparam int CH_VOLTAGE   = 1;
    localparam int N_CH         = 2;
    localparam int PEAK_HISTORY = 2;
    localparam int REPORT_LIMIT = 40;

    t_sample   limit_cfg [N_CH];
    t_time     allowed_ticks;
    t_time     band_low;
    t_time     band_high;

    t_sample   chan_prev1 [N_CH];
    t_sample   chan_prev2 [N_CH];
    t_time     chan_last_peak [N_CH];
    t_time     chan_over_total [N_CH];
    logic      chan_peak_seen [N_CH];
    logic      chan_was_over [N_CH];
    t_time     last_time;
    int        samples_seen;

    t_out_item expected_results [$];

    function automatic t_chan_res step_channel(int ch, t_sample s, t_time stamp);
        t_chan_res r;
        t_time     dt;
        t_time     span;
        logic      over;
        r    = '0;
        over = s > limit_cfg[ch];
        dt   = stamp - last_time;
        if (over && chan_was_over[ch]) begin
            if (dt > ~chan_over_total[ch]) begin
                chan_over_total[ch] = '1;
            end else begin
                chan_over_total[ch] = chan_over_total[ch] + dt;
            end
        end else begin
            chan_over_total[ch] = '0;
        end
        chan_was_over[ch] = over;
        r.over_alarm = chan_over_total[ch] > allowed_ticks;
        if (samples_seen >= PEAK_HISTORY && chan_prev1[ch] > chan_prev2[ch]
                && chan_prev1[ch] > s) begin
            if (chan_peak_seen[ch]) begin
                span           = last_time - chan_last_peak[ch];
                r.period_valid = 1'b1;
                r.period       = span;
                r.freq_alarm   = span < band_low || span > band_high;
            end
            chan_last_peak[ch] = last_time;
            chan_peak_seen[ch] = 1'b1;
        end
        chan_prev2[ch] = chan_prev1[ch];
        chan_prev1[ch] = s;
        return r;
    endfunction

    function automatic t_out_item predict_result(t_in_item req);
        t_chan_res cur;
        t_chan_res vol;
        t_out_item r;
        cur = step_channel(CH_CURRENT, t_sample'(req.current_sample), req.sample_time);
        vol = step_channel(CH_VOLTAGE, t_sample'(req.voltage_sample), req.sample_time);
        last_time = req.sample_time;
        if (samples_seen < PEAK_HISTORY) samples_seen++;
        r                      = '0;
        r.current_over_alarm   = cur.over_alarm;
        r.voltage_over_alarm   = vol.over_alarm;
        r.current_period_valid = cur.period_valid;
        r.current_period       = cur.period;
        r.current_freq_alarm   = cur.freq_alarm;
        r.voltage_period_valid = vol.period_valid;
        r.voltage_period       = vol.period;
        r.voltage_freq_alarm   = vol.freq_alarm;
        return r;
    endfunction

    task automatic report_mismatch(string what, t_time got, t_time want);
        if (o_fail_count < REPORT_LIMIT) begin
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        end
        o_fail_count++;
    endtask

    task automatic compare_result(t_out_item got, t_out_item want);
        if (got.current_over_alarm !== want.current_over_alarm)
            report_mismatch("current_over_alarm", t_time'(got.current_over_alarm),
                            t_time'(want.current_over_alarm));
        if (got.voltage_over_alarm !== want.voltage_over_alarm)
            report_mismatch("voltage_over_alarm", t_time'(got.voltage_over_alarm),
                            t_time'(want.voltage_over_alarm));
        if (got.current_period_valid !== want.current_period_valid)
            report_mismatch("current_period_valid", t_time'(got.current_period_valid),
                            t_time'(want.current_period_valid));
        if (got.current_period !== want.current_period)
            report_mismatch("current_period", got.current_period, want.current_period);
        if (got.current_freq_alarm !== want.current_freq_alarm)
            report_mismatch("current_freq_alarm", t_time'(got.current_freq_alarm),
                            t_time'(want.current_freq_alarm));
        if (got.voltage_period_valid !== want.voltage_period_valid)
            report_mismatch("voltage_period_valid", t_time'(got.voltage_period_valid),
                            t_time'(want.voltage_period_valid));
        if (got.voltage_period !== want.voltage_period)
            report_mismatch("voltage_period", got.voltage_period, want.voltage_period);
        if (got.voltage_freq_alarm !== want.voltage_freq_alarm)
            report_mismatch("voltage_freq_alarm", t_time'(got.voltage_freq_alarm),
                            t_time'(want.voltage_freq_alarm));
        o_checked++;
        o_periods     += int'(want.current_period_valid) + int'(want.voltage_period_valid);
        o_freq_alarms += int'(want.current_freq_alarm) + int'(want.voltage_freq_alarm);
        o_over_alarms += int'(want.current_over_alarm) + int'(want.voltage_over_alarm);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit_cfg[CH_CURRENT] = CURRENT_LIMIT_RST;
            limit_cfg[CH_VOLTAGE] = VOLTAGE_LIMIT_RST;
            allowed_ticks         = ALLOWED_OVER_TICKS_RST;
            band_low              = PERIOD_LOW_RST;
            band_high             = PERIOD_HIGH_RST;
            for (int ch = 0; ch < N_CH; ch++) begin
                chan_prev1[ch]      = '0;
                chan_prev2[ch]      = '0;
                chan_last_peak[ch]  = '0;
                chan_over_total[ch] = '0;
                chan_peak_seen[ch]  = 1'b0;
                chan_was_over[ch]   = 1'b0;
            end
            last_time    = '0;
            samples_seen = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_CURRENT_LIMIT:      limit_cfg[CH_CURRENT] = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_VOLTAGE_LIMIT:      limit_cfg[CH_VOLTAGE] = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_ALLOWED_OVER_TICKS: allowed_ticks = i_cfg_data[TIME_BITS-1:0];
                    CFG_PERIOD_LOW:         band_low = i_cfg_data[TIME_BITS-1:0];
                    CFG_PERIOD_HIGH:        band_high = i_cfg_data[TIME_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request pending", '0, '0);
                end else begin
                    compare_result(i_res, expected_results.pop_front());
                end
            end
            if (i_req_valid && !i_req_stall) begin
                expected_results = {expected_results, predict_result(i_req)};
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- bench/power_line_alarm_monitor_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// power_line_alarm_monitor_test
// Drives the alarm monitor with a short directed sequence (sample extremes,
// early samples, timestamp wrap, saturating totals, inverted and full period
// bands, stray register writes) and then with phases of noisy triangle waves
// under random settings. The sender bursts and the receiver stalls on its own
// pattern, including one long hold-off that backs the block up.
// ============================================================================
module power_line_alarm_monitor_test;
    import plam_pkg::*;

    localparam int      CLK_PERIOD    = 4;
    localparam int      RESET_CYCLES  = 8;
    localparam int      SETTLE_CYCLES = 4;
    localparam int      HOLD_CYCLES   = 64;
    localparam int      RANDOM_ITEMS  = 850;
    localparam int      TIMEOUT_NS    = 2_000_000;
    localparam t_sample SAMPLE_MAX    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample SAMPLE_MIN    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam t_time   TIME_MAX      = '1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_INDEX_UNUSED = CFG_PERIOD_HIGH + 1'b1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INDEX_TOP    = '1;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALTERNATE,
        STALL_BLOCK
    } t_stall_mode;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    t_in_item                  i_item;
    logic                      o_valid;
    logic                      i_stall;
    t_out_item                 o_result;
    logic                      i_cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    int fail_count;
    int pending;
    int checked;
    int periods;
    int freq_alarms;
    int over_alarms;

    int sent_count    = 0;
    int setting_count = 0;
    int burst_left    = 0;
    bit hold_request  = 1'b0;

    power_line_alarm_monitor u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    power_line_alarm_monitor_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_req         (i_item),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_res         (o_result),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_periods     (periods),
        .o_freq_alarms (freq_alarms),
        .o_over_alarms (over_alarms)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_sample clamp_sample(int v);
        if (v > int'(SAMPLE_MAX)) return SAMPLE_MAX;
        if (v < int'(SAMPLE_MIN)) return SAMPLE_MIN;
        return t_sample'(v);
    endfunction

    function automatic t_sample wave_sample(int k, int half, int amp, int mid, int noise);
        int pos;
        int v;
        pos = k % (2 * half);
        if (pos > half) pos = 2 * half - pos;
        v = mid - amp + (2 * amp * pos) / half;
        if (noise > 0) v += int'($urandom_range(0, 2 * noise)) - noise;
        return clamp_sample(v);
    endfunction

    function automatic t_sample pick_limit(int mid, int amp);
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            default: return clamp_sample(mid + int'($urandom_range(0, 2 * amp)) - amp);
        endcase
    endfunction

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 15);
        end
    endtask

    task automatic send_request(t_sample cur, t_sample volt, t_time stamp);
        pace();
        i_item  <= {cur, volt, stamp};
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_BITS-1:0] index,
                                  logic [CFG_DATA_BITS-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
    endtask

    task automatic load_settings(t_sample cur_limit, t_sample volt_limit, t_time allowed,
                                 t_time low, t_time high);
        logic [CFG_DATA_BITS-SAMPLE_BITS-1:0] junk_cur;
        logic [CFG_DATA_BITS-SAMPLE_BITS-1:0] junk_volt;
        logic [CFG_INDEX_BITS-1:0]            stray;
        drain_pipeline();
        junk_cur  = (CFG_DATA_BITS-SAMPLE_BITS)'($urandom);
        junk_volt = (CFG_DATA_BITS-SAMPLE_BITS)'($urandom);
        stray     = CFG_INDEX_BITS'($urandom_range(CFG_INDEX_UNUSED, CFG_INDEX_TOP));
        write_register(CFG_CURRENT_LIMIT, {junk_cur, cur_limit});
        write_register(CFG_VOLTAGE_LIMIT, {junk_volt, volt_limit});
        write_register(stray, $urandom);
        write_register(CFG_ALLOWED_OVER_TICKS, allowed);
        write_register(CFG_PERIOD_LOW, low);
        write_register(CFG_PERIOD_HIGH, high);
        i_cfg_wr_en <= 1'b0;
        setting_count++;
    endtask

    task automatic run_directed();
        send_request(5, -6, 0);
        send_request(1, -2, 1);
        send_request(SAMPLE_MAX, SAMPLE_MIN, 100);
        send_request(SAMPLE_MIN, SAMPLE_MAX, 10000);
        send_request(SAMPLE_MAX, SAMPLE_MIN, 20100);
        send_request(SAMPLE_MIN, SAMPLE_MAX, 30000);
        send_request(SAMPLE_MAX, SAMPLE_MIN, 70000);
        send_request(0, 0, 90100);
        send_request(0, 0, TIME_MAX - 15);
        send_request(SAMPLE_MAX, SAMPLE_MAX, 16);
        send_request(SAMPLE_MIN, SAMPLE_MIN, 32);

        load_settings(SAMPLE_MIN, SAMPLE_MIN, '0, TIME_MAX, '0);
        send_request(1000, -1000, 32'h1000_0000);
        send_request(-1000, 1000, 32'h9000_0000);
        send_request(1000, -1000, 32'h1000_0000);
        send_request(-1000, 1000, 32'h9000_0000);
        send_request(SAMPLE_MIN, 0, 32'h9000_0001);
        send_request(SAMPLE_MAX, SAMPLE_MIN, 32'h9000_0002);

        load_settings(t_sample'(SAMPLE_MAX - 1), 0, TIME_MAX, '0, TIME_MAX);
        send_request(SAMPLE_MAX, 5, 7);
        send_request(SAMPLE_MAX, 9, 7);
        send_request(SAMPLE_MAX, 5, 7);
        send_request(SAMPLE_MAX, 9, 7);
        send_request(SAMPLE_MAX, 5, 7);
        send_request(0, -1, 7);
    endtask

    task automatic run_random();
        int      step;
        int      jitter;
        int      half [2];
        int      amp [2];
        int      mid [2];
        int      noise [2];
        int      shift;
        int      len;
        int      nominal;
        int      slack;
        int      target;
        t_time   now;
        t_time   low;
        t_time   high;
        t_time   allowed;
        t_sample cs;
        t_sample vs;
        bit      held;
        held   = 1'b0;
        target = sent_count + RANDOM_ITEMS;
        while (sent_count < target) begin
            step   = $urandom_range(1, 400);
            jitter = $urandom_range(0, step / 4);
            for (int ch = 0; ch < 2; ch++) begin
                half[ch]  = $urandom_range(2, 12);
                amp[ch]   = $urandom_range(1, 16000);
                mid[ch]   = int'($urandom_range(0, 32000)) - 16000;
                noise[ch] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, amp[ch] / 4 + 1) : 0;
            end
            if ($urandom_range(0, 1) == 0) half[1] = half[0];
            shift = $urandom_range(0, 23);

            case ($urandom_range(0, 7))
                0:       allowed = '0;
                1:       allowed = TIME_MAX;
                default: allowed = step * $urandom_range(0, 2 * half[0]);
            endcase
            nominal = 2 * half[0] * step;
            slack   = $urandom_range(0, 2 * jitter + 1);
            low     = nominal - slack;
            high    = nominal + slack;
            case ($urandom_range(0, 7))
                0: begin
                    low  = nominal + slack + 1;
                    high = nominal - slack;
                end
                1: begin
                    low  = $urandom;
                    high = $urandom;
                end
                default: ;
            endcase
            load_settings(pick_limit(mid[0], amp[0]), pick_limit(mid[1], amp[1]),
                          allowed, low, high);
            if (!held) begin
                hold_request = 1'b1;
                held         = 1'b1;
            end

            len = $urandom_range(60, 140);
            now = $urandom;
            for (int k = 0; k < len && sent_count < target; k++) begin
                if ($urandom_range(0, 11) == 0) begin
                    cs = t_sample'($urandom);
                    vs = t_sample'($urandom);
                end else begin
                    cs = wave_sample(k, half[0], amp[0], mid[0], noise[0]);
                    vs = wave_sample(k + shift, half[1], amp[1], mid[1], noise[1]);
                end
                case ($urandom_range(0, 59))
                    0:       now = $urandom;
                    1:       ;
                    default: now = now + step + $urandom_range(0, jitter);
                endcase
                send_request(cs, vs, now);
            end
        end
    endtask

    initial begin
        t_stall_mode mode;
        int          span;
        i_stall = 1'b0;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            mode = t_stall_mode'($urandom_range(STALL_NONE, STALL_BLOCK));
            span = $urandom_range(4, 60);
            for (int n = 0; n < span && !hold_request; n++) begin
                case (mode)
                    STALL_NONE:      i_stall <= 1'b0;
                    STALL_LIGHT:     i_stall <= ($urandom_range(0, 9) < 3);
                    STALL_HEAVY:     i_stall <= ($urandom_range(0, 9) < 7);
                    STALL_ALTERNATE: i_stall <= n[0];
                    default:         i_stall <= (n < span / 2);
                endcase
                @(negedge i_clk);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        drain_pipeline();
        $display("Summary: %0d requests, %0d results checked across %0d register settings",
                 sent_count, checked, setting_count);
        $display("Summary: %0d periods measured, %0d frequency and %0d over-limit alarms seen",
                 periods, freq_alarms, over_alarms);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
